// ===== rtl/mffs_pkg.sv =====
// Package with shared types and constants of the multichannel frame FIFO.
`default_nettype none

package mffs_pkg;

  localparam int DEF_CAPACITY_FRAMES = 1024;
  localparam int DEF_MAX_CHANNELS    = 4;
  localparam int DEF_MAX_POP         = 64;

  localparam int SAMPLE_W   = 32;
  localparam int LANE_PORTS = 4;
  localparam int KIND_W     = 2;
  localparam int CHAN_W     = 3;
  localparam int POP_W      = 7;
  localparam int AVAIL_W    = 11;
  localparam int CNT_W      = 32;

  localparam logic [CHAN_W-1:0] CHAN_RESET = 3'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_STATS = 2'd3
  } kind_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_e;

  typedef struct packed {
    logic take;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pop_go;
    logic last_frame;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// ===== rtl/mffs_ctrl.sv =====
// Controller state machine that sequences transactions and frame delivery.
`default_nettype none

module mffs_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire mffs_pkg::ctrl_sts_t sts_i,
  output mffs_pkg::ctrl_cmd_t     cmd_o
);

  mffs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mffs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      mffs_pkg::ST_IDLE: begin
        if (in_valid_i && sts_i.out_free && sts_i.pop_go) begin
          state_d = mffs_pkg::ST_EMIT;
        end
      end
      mffs_pkg::ST_EMIT: begin
        if (sts_i.out_free && sts_i.last_frame) begin
          state_d = mffs_pkg::ST_IDLE;
        end
      end
      default: state_d = mffs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o.take  = 1'b0;
    cmd_o.emit  = 1'b0;
    case (state_q)
      mffs_pkg::ST_IDLE: begin
        in_ready_o = sts_i.out_free;
        cmd_o.take = in_valid_i && sts_i.out_free;
      end
      mffs_pkg::ST_EMIT: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/mffs_datapath.sv =====
// Datapath with frame memory, pointers, statistics counters and output register.
`default_nettype none

module mffs_datapath #(
  parameter int CAPACITY_FRAMES = mffs_pkg::DEF_CAPACITY_FRAMES,
  parameter int MAX_CHANNELS    = mffs_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_POP         = mffs_pkg::DEF_MAX_POP
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire mffs_pkg::ctrl_cmd_t               cmd_i,
  output mffs_pkg::ctrl_sts_t                    sts_o,
  input  wire logic                              cfg_valid_i,
  input  wire logic [mffs_pkg::CHAN_W-1:0]       cfg_data_i,
  input  wire logic [mffs_pkg::KIND_W-1:0]       kind_i,
  input  wire logic [mffs_pkg::SAMPLE_W-1:0]     sample_0_i,
  input  wire logic [mffs_pkg::SAMPLE_W-1:0]     sample_1_i,
  input  wire logic [mffs_pkg::SAMPLE_W-1:0]     sample_2_i,
  input  wire logic [mffs_pkg::SAMPLE_W-1:0]     sample_3_i,
  input  wire logic [mffs_pkg::POP_W-1:0]        pop_count_i,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic [mffs_pkg::SAMPLE_W-1:0]          out_sample_0_o,
  output logic [mffs_pkg::SAMPLE_W-1:0]          out_sample_1_o,
  output logic [mffs_pkg::SAMPLE_W-1:0]          out_sample_2_o,
  output logic [mffs_pkg::SAMPLE_W-1:0]          out_sample_3_o,
  output logic                                   frame_valid_o,
  output logic                                   last_o,
  output logic [mffs_pkg::AVAIL_W-1:0]           available_frames_o,
  output logic [mffs_pkg::CNT_W-1:0]             pushed_total_o,
  output logic [mffs_pkg::CNT_W-1:0]             popped_total_o,
  output logic [mffs_pkg::CNT_W-1:0]             overrun_total_o,
  output logic [mffs_pkg::CNT_W-1:0]             underrun_total_o
);

  localparam int SW    = mffs_pkg::SAMPLE_W;
  localparam int LP    = mffs_pkg::LANE_PORTS;
  localparam int LANES = (MAX_CHANNELS < LP) ? MAX_CHANNELS : LP;
  localparam int RW    = LANES * SW;
  localparam int AW    = $clog2(CAPACITY_FRAMES);
  localparam int PW    = AW + 1;
  localparam int CW    = (PW > mffs_pkg::POP_W) ? PW : mffs_pkg::POP_W;
  localparam int FW    = (PW > mffs_pkg::AVAIL_W) ? PW : mffs_pkg::AVAIL_W;
  localparam int NW    = mffs_pkg::POP_W;
  localparam int CNW   = mffs_pkg::CNT_W;

  logic [RW-1:0] mem_q [CAPACITY_FRAMES];
  logic [RW-1:0] rdata_q;

  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNW-1:0] pushed_q, pushed_d, popped_q, popped_d;
  logic [CNW-1:0] over_q, over_d, under_q, under_d;
  logic [mffs_pkg::CHAN_W-1:0] chan_q;
  logic [NW-1:0] remain_q, remain_d, short_q, short_d;
  logic out_valid_q, out_valid_d, out_frame_q, out_frame_d, out_last_q, out_last_d;
  logic [LP*SW-1:0] out_smp_q, out_smp_d;

  logic [PW-1:0] fill;
  logic [FW-1:0] fill_ext;
  logic          full;
  logic [NW-1:0] asked, n_frames;
  logic          pop_go, last_frame, out_free, load_out;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_raddr;
  logic [LP*SW-1:0] wfull, rdata_pad, lanes_masked;
  logic [RW-1:0] wdata;
  logic [mffs_pkg::CHAN_W-1:0] nch;
  mffs_pkg::kind_e kind;

  assign kind       = mffs_pkg::kind_e'(kind_i);
  assign fill       = wr_q - rd_q;
  assign fill_ext   = FW'(fill);
  assign full       = fill[PW-1];
  assign asked      = (pop_count_i > NW'(MAX_POP)) ? NW'(MAX_POP) : pop_count_i;
  assign n_frames   = (CW'(asked) < CW'(fill)) ? asked : NW'(CW'(fill));
  assign pop_go     = (kind == mffs_pkg::KIND_POP) && (n_frames != '0);
  assign last_frame = (remain_q == NW'(1));
  assign out_free   = !out_valid_q || out_ready_i;
  assign load_out   = (cmd_i.take && !pop_go) || cmd_i.emit;

  assign sts_o.pop_go     = pop_go;
  assign sts_o.last_frame = last_frame;
  assign sts_o.out_free   = out_free;

  assign wfull     = {sample_3_i, sample_2_i, sample_1_i, sample_0_i};
  assign wdata     = wfull[RW-1:0];
  assign rdata_pad = (LP*SW)'(rdata_q);
  assign mem_we    = cmd_i.take && (kind == mffs_pkg::KIND_PUSH) && !full;
  assign mem_re    = (cmd_i.take && pop_go) || (cmd_i.emit && !last_frame);
  assign mem_raddr = cmd_i.emit ? AW'(rd_q + PW'(1)) : rd_q[AW-1:0];

  always_comb begin
    if (chan_q == '0) begin
      nch = mffs_pkg::CHAN_W'(1);
    end else if (chan_q > mffs_pkg::CHAN_W'(LANES)) begin
      nch = mffs_pkg::CHAN_W'(LANES);
    end else begin
      nch = chan_q;
    end
  end

  always_comb begin
    for (int j = 0; j < LP; j++) begin
      if (mffs_pkg::CHAN_W'(j) < nch) begin
        lanes_masked[j*SW +: SW] = rdata_pad[j*SW +: SW];
      end else begin
        lanes_masked[j*SW +: SW] = '0;
      end
    end
  end

  always_comb begin
    wr_d        = wr_q;
    rd_d        = rd_q;
    pushed_d    = pushed_q;
    popped_d    = popped_q;
    over_d      = over_q;
    under_d     = under_q;
    remain_d    = remain_q;
    short_d     = short_q;
    out_smp_d   = out_smp_q;
    out_frame_d = out_frame_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (load_out) begin
      out_valid_d = 1'b1;
    end
    if (cmd_i.take) begin
      out_smp_d   = '0;
      out_frame_d = 1'b0;
      out_last_d  = 1'b1;
      case (kind)
        mffs_pkg::KIND_PUSH: begin
          if (full) begin
            over_d = over_q + CNW'(1);
          end else begin
            wr_d        = wr_q + PW'(1);
            pushed_d    = pushed_q + CNW'(1);
            out_frame_d = 1'b1;
          end
        end
        mffs_pkg::KIND_POP: begin
          remain_d = n_frames;
          short_d  = asked - n_frames;
        end
        mffs_pkg::KIND_CLEAR: begin
          rd_d = wr_q;
        end
        mffs_pkg::KIND_STATS: begin
          pushed_d = '0;
          popped_d = '0;
          over_d   = '0;
          under_d  = '0;
        end
        default: begin
          rd_d = rd_q;
        end
      endcase
    end
    if (cmd_i.emit) begin
      out_smp_d   = lanes_masked;
      out_frame_d = 1'b1;
      out_last_d  = last_frame;
      rd_d        = rd_q + PW'(1);
      popped_d    = popped_q + CNW'(1);
      remain_d    = remain_q - NW'(1);
      if (last_frame) begin
        under_d = under_q + CNW'(short_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q        <= '0;
      rd_q        <= '0;
      pushed_q    <= '0;
      popped_q    <= '0;
      over_q      <= '0;
      under_q     <= '0;
      chan_q      <= mffs_pkg::CHAN_RESET;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      wr_q        <= wr_d;
      rd_q        <= rd_d;
      pushed_q    <= pushed_d;
      popped_q    <= popped_d;
      over_q      <= over_d;
      under_q     <= under_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        chan_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    short_q     <= short_d;
    out_smp_q   <= out_smp_d;
    out_frame_q <= out_frame_d;
    out_last_q  <= out_last_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_q[AW-1:0]] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_sample_0_o     = out_smp_q[0*SW +: SW];
  assign out_sample_1_o     = out_smp_q[1*SW +: SW];
  assign out_sample_2_o     = out_smp_q[2*SW +: SW];
  assign out_sample_3_o     = out_smp_q[3*SW +: SW];
  assign frame_valid_o      = out_frame_q;
  assign last_o             = out_last_q;
  assign available_frames_o = fill_ext[mffs_pkg::AVAIL_W-1:0];
  assign pushed_total_o     = pushed_q;
  assign popped_total_o     = popped_q;
  assign overrun_total_o    = over_q;
  assign underrun_total_o   = under_q;

endmodule

`default_nettype wire

// ===== rtl/multichannel_frame_fifo_with_stats_core.sv =====
// Top level of the multichannel frame FIFO with statistics counters.
// Push, clear, stats-reset and zero-frame pops give their result in the cycle after acceptance.
// Pop frames pass the memory read register, then the output register, one per cycle unless stalled.
// The one frame-memory read port limits pops to one frame per cycle unless the output stalls.
// The next input transaction is accepted once the last frame of a pop is registered.
// Asynchronous reset clears pointers and counters and sets channels to two; memory is not cleared.
`default_nettype none

module multichannel_frame_fifo_with_stats_core #(
  parameter int CAPACITY_FRAMES = mffs_pkg::DEF_CAPACITY_FRAMES,
  parameter int MAX_CHANNELS    = mffs_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_POP         = mffs_pkg::DEF_MAX_POP
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [mffs_pkg::CHAN_W-1:0]       cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [mffs_pkg::KIND_W-1:0]       kind_i,
  input  wire logic [mffs_pkg::SAMPLE_W-1:0]     sample_0_i,
  input  wire logic [mffs_pkg::SAMPLE_W-1:0]     sample_1_i,
  input  wire logic [mffs_pkg::SAMPLE_W-1:0]     sample_2_i,
  input  wire logic [mffs_pkg::SAMPLE_W-1:0]     sample_3_i,
  input  wire logic [mffs_pkg::POP_W-1:0]        pop_count_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [mffs_pkg::SAMPLE_W-1:0]          out_sample_0_o,
  output logic [mffs_pkg::SAMPLE_W-1:0]          out_sample_1_o,
  output logic [mffs_pkg::SAMPLE_W-1:0]          out_sample_2_o,
  output logic [mffs_pkg::SAMPLE_W-1:0]          out_sample_3_o,
  output logic                                   frame_valid_o,
  output logic                                   last_o,
  output logic [mffs_pkg::AVAIL_W-1:0]           available_frames_o,
  output logic [mffs_pkg::CNT_W-1:0]             pushed_total_o,
  output logic [mffs_pkg::CNT_W-1:0]             popped_total_o,
  output logic [mffs_pkg::CNT_W-1:0]             overrun_total_o,
  output logic [mffs_pkg::CNT_W-1:0]             underrun_total_o
);

  mffs_pkg::ctrl_cmd_t cmd;
  mffs_pkg::ctrl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  mffs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mffs_datapath #(
    .CAPACITY_FRAMES (CAPACITY_FRAMES),
    .MAX_CHANNELS    (MAX_CHANNELS),
    .MAX_POP         (MAX_POP)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_data_i         (cfg_data_i),
    .kind_i             (kind_i),
    .sample_0_i         (sample_0_i),
    .sample_1_i         (sample_1_i),
    .sample_2_i         (sample_2_i),
    .sample_3_i         (sample_3_i),
    .pop_count_i        (pop_count_i),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .out_sample_0_o     (out_sample_0_o),
    .out_sample_1_o     (out_sample_1_o),
    .out_sample_2_o     (out_sample_2_o),
    .out_sample_3_o     (out_sample_3_o),
    .frame_valid_o      (frame_valid_o),
    .last_o             (last_o),
    .available_frames_o (available_frames_o),
    .pushed_total_o     (pushed_total_o),
    .popped_total_o     (popped_total_o),
    .overrun_total_o    (overrun_total_o),
    .underrun_total_o   (underrun_total_o)
  );

endmodule

`default_nettype wire
